// ===== hdl/frt_pkg.sv =====
`default_nettype none

package frt_pkg;

  // Default frame limits, handed to the top level as parameter defaults.
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  // Fixed field widths.
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 5;

  // Register indexes, taken from the word address of the configuration port.
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_ROTATE_MODE  = 3'd2,
    REG_MAX_VALUE    = 3'd3,
    REG_RANGE_CHECK  = 3'd4
  } reg_idx_t;

  // Input word operation codes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  // Output orientation codes.
  localparam logic ROT_TRANSPOSE = 1'b0;
  localparam logic ROT_CLOCKWISE = 1'b1;

  // Register reset values.
  localparam logic [DIM_W-1:0]    IMAGE_DIM_RST   = 9'd256;
  localparam logic                ROTATE_MODE_RST = ROT_CLOCKWISE;
  localparam logic [SAMPLE_W-1:0] MAX_VALUE_RST   = 16'd255;
  localparam logic                RANGE_CHECK_RST = 1'b0;

  // Input word: a load or a fetch request.
  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
  } in_word_t;

  // Output word: one fetched pixel with its flags.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               row_end;
    logic               frame_end;
    logic               range_error;
  } out_word_t;

  // Configuration seen by the address generator.
  typedef struct packed {
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic                rotate_mode;
    logic [SAMPLE_W-1:0] max_value;
    logic                range_check;
    logic                pos_clear;
  } cfg_t;

  // Flags that go with one fetch.
  typedef struct packed {
    logic row_end;
    logic frame_end;
    logic range_error;
  } fetch_info_t;

  // Saturate a dimension to the range 1..maxv.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                 input int unsigned maxv);
    logic [DIM_W-1:0] res;
    res = d;
    if (d == '0) begin
      res = DIM_W'(1);
    end else if (32'(d) > maxv) begin
      res = DIM_W'(maxv);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/frt_stream_if.sv =====
`default_nettype none

// Valid/ready channel carrying one word of the given payload type.
interface frt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/frt_cfg_regs.sv =====
`default_nettype none

module frt_cfg_regs #(
  parameter int unsigned MAX_WIDTH  = frt_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = frt_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [frt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [frt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [frt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output frt_pkg::cfg_t                        cfg
);

  logic [frt_pkg::DIM_W-1:0]    width_r, width_nxt;
  logic [frt_pkg::DIM_W-1:0]    height_r, height_nxt;
  logic                         rotate_r, rotate_nxt;
  logic [frt_pkg::SAMPLE_W-1:0] maxval_r, maxval_nxt;
  logic                         check_r, check_nxt;
  logic                         clear_r, clear_nxt;
  logic                         wr_en;
  frt_pkg::reg_idx_t            idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = frt_pkg::reg_idx_t'(paddr[4:2]);

  // Register write decode. A dimension write also restarts both scan positions.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    rotate_nxt = rotate_r;
    maxval_nxt = maxval_r;
    check_nxt  = check_r;
    clear_nxt  = 1'b0;
    if (wr_en) begin
      unique case (idx)
        frt_pkg::REG_IMAGE_WIDTH: begin
          width_nxt = frt_pkg::clamp_dim(pwdata[frt_pkg::DIM_W-1:0], MAX_WIDTH);
          clear_nxt = 1'b1;
        end
        frt_pkg::REG_IMAGE_HEIGHT: begin
          height_nxt = frt_pkg::clamp_dim(pwdata[frt_pkg::DIM_W-1:0], MAX_HEIGHT);
          clear_nxt  = 1'b1;
        end
        frt_pkg::REG_ROTATE_MODE: rotate_nxt = pwdata[0];
        frt_pkg::REG_MAX_VALUE:   maxval_nxt = pwdata[frt_pkg::SAMPLE_W-1:0];
        frt_pkg::REG_RANGE_CHECK: check_nxt  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= frt_pkg::clamp_dim(frt_pkg::IMAGE_DIM_RST, MAX_WIDTH);
      height_r <= frt_pkg::clamp_dim(frt_pkg::IMAGE_DIM_RST, MAX_HEIGHT);
      rotate_r <= frt_pkg::ROTATE_MODE_RST;
      maxval_r <= frt_pkg::MAX_VALUE_RST;
      check_r  <= frt_pkg::RANGE_CHECK_RST;
      clear_r  <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      rotate_r <= rotate_nxt;
      maxval_r <= maxval_nxt;
      check_r  <= check_nxt;
      clear_r  <= clear_nxt;
    end
  end

  // Read back mux.
  always_comb begin
    prdata = '0;
    unique case (idx)
      frt_pkg::REG_IMAGE_WIDTH:  prdata = frt_pkg::CFG_DATA_W'(width_r);
      frt_pkg::REG_IMAGE_HEIGHT: prdata = frt_pkg::CFG_DATA_W'(height_r);
      frt_pkg::REG_ROTATE_MODE:  prdata = frt_pkg::CFG_DATA_W'(rotate_r);
      frt_pkg::REG_MAX_VALUE:    prdata = frt_pkg::CFG_DATA_W'(maxval_r);
      frt_pkg::REG_RANGE_CHECK:  prdata = frt_pkg::CFG_DATA_W'(check_r);
      default:                   prdata = '0;
    endcase
  end

  assign cfg.image_width  = width_r;
  assign cfg.image_height = height_r;
  assign cfg.rotate_mode  = rotate_r;
  assign cfg.max_value    = maxval_r;
  assign cfg.range_check  = check_r;
  assign cfg.pos_clear    = clear_r;

endmodule

`default_nettype wire

// ===== hdl/frt_addr_gen.sv =====
`default_nettype none

module frt_addr_gen #(
  parameter int unsigned MAX_WIDTH  = frt_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = frt_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH),
  localparam int unsigned ROW_W     = $clog2(MAX_HEIGHT),
  localparam int unsigned AW        = ROW_W + COL_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire frt_pkg::cfg_t                   cfg,
  input  wire logic                            load_acc,
  input  wire logic                            fetch_acc,
  input  wire logic [frt_pkg::SAMPLE_W-1:0]    sample,
  output logic      [AW-1:0]                   mem_addr,
  output logic                                 mem_we,
  output logic                                 mem_re,
  output logic      [frt_pkg::PIXEL_W-1:0]     mem_wdata,
  output frt_pkg::fetch_info_t                 info
);

  // Load scan position (raster order) and fetch scan position (output order).
  logic [ROW_W-1:0] load_row_r, load_row_nxt;
  logic [COL_W-1:0] load_col_r, load_col_nxt;
  logic [COL_W-1:0] out_row_r, out_row_nxt;
  logic [ROW_W-1:0] out_col_r, out_col_nxt;
  logic             error_r, error_nxt;
  logic             load_last_col, load_last_row;
  logic             out_last_col, out_last_row;
  logic [ROW_W-1:0] src_row;

  assign load_last_col = (32'(load_col_r) + 32'd1) >= 32'(cfg.image_width);
  assign load_last_row = (32'(load_row_r) + 32'd1) >= 32'(cfg.image_height);
  assign out_last_col  = (32'(out_col_r) + 32'd1) >= 32'(cfg.image_height);
  assign out_last_row  = (32'(out_row_r) + 32'd1) >= 32'(cfg.image_width);

  // Source row of the fetched pixel: mirrored for a clockwise rotation.
  assign src_row = (cfg.rotate_mode == frt_pkg::ROT_CLOCKWISE)
                   ? ROW_W'(32'(cfg.image_height) - 32'd1 - 32'(out_col_r))
                   : out_col_r;

  // One memory access per word: a write for a load, a read for a fetch.
  assign mem_we    = load_acc;
  assign mem_re    = fetch_acc;
  assign mem_wdata = sample[frt_pkg::PIXEL_W-1:0];
  assign mem_addr  = fetch_acc ? {src_row, out_row_r} : {load_row_r, load_col_r};

  assign info.row_end     = out_last_col;
  assign info.frame_end   = out_last_col && out_last_row;
  assign info.range_error = error_r;

  // Position counters and sticky range error.
  always_comb begin
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    error_nxt    = error_r;
    if (cfg.pos_clear) begin
      load_row_nxt = '0;
      load_col_nxt = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
    end else begin
      if (load_acc) begin
        if (cfg.range_check && (sample > cfg.max_value)) begin
          error_nxt = 1'b1;
        end
        if (load_last_col) begin
          load_col_nxt = '0;
          load_row_nxt = load_last_row ? '0 : load_row_r + ROW_W'(1);
        end else begin
          load_col_nxt = load_col_r + COL_W'(1);
        end
      end
      if (fetch_acc) begin
        if (out_last_col) begin
          out_col_nxt = '0;
          out_row_nxt = out_last_row ? '0 : out_row_r + COL_W'(1);
        end else begin
          out_col_nxt = out_col_r + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= '0;
      load_col_r <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      error_r    <= 1'b0;
    end else begin
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      error_r    <= error_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/frt_frame_mem.sv =====
`default_nettype none

module frt_frame_mem #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = frt_pkg::PIXEL_W
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  // Single-port frame store, row in the upper address bits.
  logic [DW-1:0] store_r [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[addr] <= wdata;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= store_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/frame_rotate_transpose.sv =====
// Frame buffer for 8-bit grey pixels: load words (mode 0) write the frame in raster
// order, fetch words (mode 1) read it back transposed or rotated ninety degrees
// clockwise, one output row of image_height pixels per input column. Words may follow
// each other back to back; the single-port frame memory does one access per word, a
// write for a load or a read for a fetch, and a fetched pixel is offered on the output
// in the cycle after its fetch word is accepted. Input stalls only while a fetched
// result waits to be taken. The frame memory is not cleared, so pixels must be loaded
// before they are fetched. Dimension writes restart both the load and the fetch
// position; configuration is to be written while idle (not enforced by the block).
`default_nettype none

module frame_rotate_transpose #(
  parameter int unsigned MAX_WIDTH  = frt_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = frt_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  frt_stream_if.sink                           in_s,
  frt_stream_if.source                         out_s,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [frt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [frt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [frt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  localparam int unsigned AW = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);

  frt_pkg::cfg_t                cfg;
  frt_pkg::fetch_info_t         info;
  logic                         in_acc, load_acc, fetch_acc;
  logic [AW-1:0]                mem_addr;
  logic                         mem_we, mem_re;
  logic [frt_pkg::PIXEL_W-1:0]  mem_wdata, mem_rdata;
  logic                         out_valid_r, out_valid_nxt;
  frt_pkg::fetch_info_t         flags_r;

  frt_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input handshake: a fetch result may leave while the next word enters.
  assign in_s.ready = !out_valid_r || out_s.ready;
  assign in_acc     = in_s.valid && in_s.ready;
  assign load_acc   = in_acc && (in_s.data.mode == frt_pkg::MODE_LOAD);
  assign fetch_acc  = in_acc && (in_s.data.mode == frt_pkg::MODE_FETCH);

  frt_addr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .load_acc  (load_acc),
    .fetch_acc (fetch_acc),
    .sample    (in_s.data.sample),
    .mem_addr  (mem_addr),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_wdata (mem_wdata),
    .info      (info)
  );

  frt_frame_mem #(
    .AW (AW),
    .DW (frt_pkg::PIXEL_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Output word register: flags are captured with the memory read.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fetch_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_s.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_acc) begin
      flags_r <= info;
    end
  end

  assign out_s.valid            = out_valid_r;
  assign out_s.data.pixel       = mem_rdata;
  assign out_s.data.row_end     = flags_r.row_end;
  assign out_s.data.frame_end   = flags_r.frame_end;
  assign out_s.data.range_error = flags_r.range_error;

`ifndef NO_ASSERTIONS
  // The single memory port never sees a read and a write together.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("frame memory read and written in the same cycle");

  // An accepted fetch always produces an output word in the next cycle.
  a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_acc |=> out_valid_r)
    else $error("fetch accepted without a result");

  // The end of a frame is always the end of an output row.
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && flags_r.frame_end) |-> flags_r.row_end)
    else $error("frame end without row end");

  // A waiting result blocks further input until it is taken.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_s.ready) |-> !in_s.ready)
    else $error("input accepted over a stalled result");
`endif

endmodule

`default_nettype wire
